// ===== src/rfk_pkg.sv =====
// ----------------------------------------------------------------------------
// rfk_pkg
// Shared widths and beat types for the radial force kernel.
// ----------------------------------------------------------------------------
package rfk_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CW          = COORD_WIDTH;
    localparam int SQ_W        = 2 * CW;          // squared offset
    localparam int ROOT_W      = CW + 8;          // distance, Q.8
    localparam int RAD_W       = 2 * ROOT_W;      // radicand, d2 << 16
    localparam int REM_W       = ROOT_W + 4;      // root remainder
    localparam int NUM_W       = CW + 22;         // dividend width
    localparam int Q_W         = 15;              // unit / falloff quotient
    localparam int S_W         = 16;              // strength width
    localparam int P1_W        = 2 * Q_W;         // unit * falloff
    localparam int P2_W        = P1_W + S_W;      // * |strength|
    localparam int M_W         = P2_W - 28;       // magnitude after >> 28

    typedef struct packed {
        logic            in_range;
        logic            req;
        logic            neg_x;
        logic            neg_y;
        logic            neg_s;
        logic [S_W-1:0]  mag_s;
        logic [CW-1:0]   ax;
        logic [CW-1:0]   ay;
        logic [CW-1:0]   reach;
    } ctx_t;

    typedef struct packed {
        logic [15:0] force_x;
        logic [15:0] force_y;
        logic        applied;
        logic        recolor;
    } res_t;

endpackage

// ===== src/rfk_front.sv =====
// ----------------------------------------------------------------------------
// rfk_front
// Offsets, squares and the radius test: three register stages.
// ----------------------------------------------------------------------------
module rfk_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rfk_pkg::CW-1:0]        particle_x,
    input  logic [rfk_pkg::CW-1:0]        particle_y,
    input  logic [rfk_pkg::CW-1:0]        centre_x,
    input  logic [rfk_pkg::CW-1:0]        centre_y,
    input  logic [rfk_pkg::CW-1:0]        reach,
    input  logic signed [rfk_pkg::S_W-1:0] strength,
    input  logic                          recolor_request,
    output logic                          out_valid,
    output rfk_pkg::ctx_t                 out_ctx,
    output logic [rfk_pkg::SQ_W-1:0]      out_d2
);
    import rfk_pkg::*;

    logic             va_reg, vb_reg, vc_reg;
    ctx_t             ca_reg, cb_reg, cc_reg;
    ctx_t             ca_next, cc_next;
    logic [SQ_W-1:0]  dx2_reg, dy2_reg, r2_reg, d2_reg;
    logic [SQ_W:0]    sum;

    always_comb begin
        ca_next        = '0;
        ca_next.req    = recolor_request;
        ca_next.neg_x  = particle_x < centre_x;
        ca_next.neg_y  = particle_y < centre_y;
        ca_next.ax     = ca_next.neg_x ? centre_x - particle_x : particle_x - centre_x;
        ca_next.ay     = ca_next.neg_y ? centre_y - particle_y : particle_y - centre_y;
        ca_next.neg_s  = strength[S_W-1];
        ca_next.mag_s  = strength[S_W-1] ? S_W'(-strength) : strength;
        ca_next.reach  = reach;
    end

    always_comb begin
        sum              = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        cc_next          = cb_reg;
        cc_next.in_range = (cb_reg.ax < cb_reg.reach) && (cb_reg.ay < cb_reg.reach)
                           && (sum < {1'b0, r2_reg}) && (sum != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ca_reg  <= ca_next;
            cb_reg  <= ca_reg;
            dx2_reg <= ca_reg.ax * ca_reg.ax;
            dy2_reg <= ca_reg.ay * ca_reg.ay;
            r2_reg  <= ca_reg.reach * ca_reg.reach;
            cc_reg  <= cc_next;
            d2_reg  <= sum[SQ_W-1:0];
        end
    end

    assign out_valid = vc_reg;
    assign out_ctx   = cc_reg;
    assign out_d2    = d2_reg;

endmodule

// ===== src/rfk_sqrt.sv =====
// ----------------------------------------------------------------------------
// rfk_sqrt
// Pipelined digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rfk_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  rfk_pkg::ctx_t               in_ctx,
    input  logic [rfk_pkg::SQ_W-1:0]    in_d2,
    output logic                        out_valid,
    output rfk_pkg::ctx_t               out_ctx,
    output logic [rfk_pkg::ROOT_W-1:0]  out_dist
);
    import rfk_pkg::*;

    logic              v_reg    [ROOT_W];
    ctx_t              ctx_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_in;
        ctx_t              ctx_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign ctx_in  = in_ctx;
            assign rad_in  = {in_d2, 16'b0};
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign ctx_in  = ctx_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[2*(ROOT_W-1-k)+1 -: 2]};
            trial  = REM_W'({root_in, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_reg[k]  <= ctx_in;
                rad_reg[k]  <= rad_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_ctx   = ctx_reg[ROOT_W-1];
    assign out_dist  = root_reg[ROOT_W-1];

endmodule

// ===== src/rfk_div.sv =====
// ----------------------------------------------------------------------------
// rfk_div
// Three restoring dividers side by side: unit x, unit y and falloff,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module rfk_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  rfk_pkg::ctx_t               in_ctx,
    input  logic [rfk_pkg::ROOT_W-1:0]  in_dist,
    output logic                        out_valid,
    output rfk_pkg::ctx_t               out_ctx,
    output logic [rfk_pkg::Q_W-1:0]     unit_x,
    output logic [rfk_pkg::Q_W-1:0]     unit_y,
    output logic [rfk_pkg::Q_W-1:0]     fall
);
    import rfk_pkg::*;

    logic              v_reg   [Q_W];
    ctx_t              ctx_reg [Q_W];
    logic [ROOT_W-1:0] du_reg  [Q_W];
    logic [ROOT_W-1:0] df_reg  [Q_W];
    logic [NUM_W-1:0]  rx_reg  [Q_W];
    logic [NUM_W-1:0]  ry_reg  [Q_W];
    logic [NUM_W-1:0]  rf_reg  [Q_W];
    logic [Q_W-1:0]    qx_reg  [Q_W];
    logic [Q_W-1:0]    qy_reg  [Q_W];
    logic [Q_W-1:0]    qf_reg  [Q_W];

    function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                                input logic [ROOT_W-1:0] den,
                                                input int unsigned sh);
        logic [NUM_W-1:0] d;
        d = NUM_W'(den) << sh;
        if (rem >= d) begin
            return {1'b1, rem - d};
        end
        return {1'b0, rem};
    endfunction

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic              v_in;
        ctx_t              ctx_in;
        logic [ROOT_W-1:0] du_in, df_in;
        logic [NUM_W-1:0]  rx_in, ry_in, rf_in;
        logic [Q_W-1:0]    qx_in, qy_in, qf_in;
        logic [NUM_W:0]    sx, sy, sf;

        if (k == 0) begin : g_first
            logic [ROOT_W-1:0] big_r;
            assign big_r  = {in_ctx.reach, 8'b0};
            assign v_in   = in_valid;
            assign ctx_in = in_ctx;
            assign du_in  = in_dist;
            assign df_in  = big_r;
            assign rx_in  = {in_ctx.ax, 22'b0};
            assign ry_in  = {in_ctx.ay, 22'b0};
            assign rf_in  = {big_r - in_dist, 14'b0};
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign qf_in  = '0;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign ctx_in = ctx_reg[k-1];
            assign du_in  = du_reg[k-1];
            assign df_in  = df_reg[k-1];
            assign rx_in  = rx_reg[k-1];
            assign ry_in  = ry_reg[k-1];
            assign rf_in  = rf_reg[k-1];
            assign qx_in  = qx_reg[k-1];
            assign qy_in  = qy_reg[k-1];
            assign qf_in  = qf_reg[k-1];
        end

        always_comb begin
            sx = div_step(rx_in, du_in, Q_W - 1 - k);
            sy = div_step(ry_in, du_in, Q_W - 1 - k);
            sf = div_step(rf_in, df_in, Q_W - 1 - k);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_reg[k] <= ctx_in;
                du_reg[k]  <= du_in;
                df_reg[k]  <= df_in;
                rx_reg[k]  <= sx[NUM_W-1:0];
                ry_reg[k]  <= sy[NUM_W-1:0];
                rf_reg[k]  <= sf[NUM_W-1:0];
                qx_reg[k]  <= {qx_in[Q_W-2:0], sx[NUM_W]};
                qy_reg[k]  <= {qy_in[Q_W-2:0], sy[NUM_W]};
                qf_reg[k]  <= {qf_in[Q_W-2:0], sf[NUM_W]};
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_ctx   = ctx_reg[Q_W-1];
    assign unit_x    = qx_reg[Q_W-1];
    assign unit_y    = qy_reg[Q_W-1];
    assign fall      = qf_reg[Q_W-1];

endmodule

// ===== src/rfk_scale.sv =====
// ----------------------------------------------------------------------------
// rfk_scale
// Two multiply stages, then sign and Q8.8 saturation.
// ----------------------------------------------------------------------------
module rfk_scale (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  rfk_pkg::ctx_t            in_ctx,
    input  logic [rfk_pkg::Q_W-1:0]  unit_x,
    input  logic [rfk_pkg::Q_W-1:0]  unit_y,
    input  logic [rfk_pkg::Q_W-1:0]  fall,
    output logic                     out_valid,
    output rfk_pkg::res_t            out_res
);
    import rfk_pkg::*;

    logic            v1_reg, v2_reg, v3_reg;
    ctx_t            c1_reg, c2_reg;
    logic [P1_W-1:0] p1x_reg, p1y_reg;
    logic [P2_W-1:0] p2x_reg, p2y_reg;
    res_t            res_reg, res_next;

    function automatic logic [15:0] sat(input logic [M_W-1:0] m, input logic neg);
        if (neg && m != '0) begin
            if (m > M_W'(32768)) begin
                return 16'h8000;
            end
            return 16'(~m + 1'b1);
        end
        if (m > M_W'(32767)) begin
            return 16'h7fff;
        end
        return m[15:0];
    endfunction

    always_comb begin
        res_next = '0;
        if (c2_reg.in_range) begin
            res_next.force_x = sat(p2x_reg[P2_W-1:28], c2_reg.neg_x != c2_reg.neg_s);
            res_next.force_y = sat(p2y_reg[P2_W-1:28], c2_reg.neg_y != c2_reg.neg_s);
            res_next.applied = 1'b1;
            res_next.recolor = c2_reg.req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg  <= in_ctx;
            p1x_reg <= unit_x * fall;
            p1y_reg <= unit_y * fall;
            c2_reg  <= c1_reg;
            p2x_reg <= p1x_reg * c1_reg.mag_s;
            p2y_reg <= p1y_reg * c1_reg.mag_s;
            res_reg <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_res   = res_reg;

endmodule

// ===== src/radial_force_kernel.sv =====
// ----------------------------------------------------------------------------
// radial_force_kernel
// Radial force of one centre on one particle, saturated to signed Q8.8.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  s_      | in  | px, py, cx, cy, reach, strength (96b)  | recolor_request
//  m_      | out | force_x, force_y (32b)                 | applied, recolor
//
//  One beat per cycle in and out while the output is not stalled; register stages:
//  3 front, 24 square root, 15 divider, 3 scale and 1 output, the root and
//  divider counts set by their bit-per-stage design.
//  Synchronous active-low reset clears all valid bits and the skid stage.
//  A stalled output beat parks in a skid register; the whole pipeline
//  freezes only while the skid register is full.
// ----------------------------------------------------------------------------
module radial_force_kernel (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // particle_x, particle_y, centre_x, centre_y, reach, strength
    input  logic [0:0]   s_tuser,   // recolor_request
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // force_x, force_y
    output logic [1:0]   m_tuser    // applied, recolor
);
    import rfk_pkg::*;

    logic              en;
    logic              fv, sv, dv, pv;
    ctx_t              fc, sc, dc;
    logic [SQ_W-1:0]   d2;
    logic [ROOT_W-1:0] dist_q;
    logic [Q_W-1:0]    ux, uy, fl;
    res_t              pres;

    logic out_valid_reg, out_valid_next;
    logic skid_full_reg, skid_full_next;
    res_t out_reg, out_next, skid_reg, skid_next;

    assign en       = !skid_full_reg;
    assign s_tready = en;

    rfk_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (s_tvalid),
        .particle_x      (s_tdata[15:0]),
        .particle_y      (s_tdata[31:16]),
        .centre_x        (s_tdata[47:32]),
        .centre_y        (s_tdata[63:48]),
        .reach           (s_tdata[79:64]),
        .strength        (s_tdata[95:80]),
        .recolor_request (s_tuser[0]),
        .out_valid       (fv),
        .out_ctx         (fc),
        .out_d2          (d2)
    );

    rfk_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fv),
        .in_ctx    (fc),
        .in_d2     (d2),
        .out_valid (sv),
        .out_ctx   (sc),
        .out_dist  (dist_q)
    );

    rfk_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sv),
        .in_ctx    (sc),
        .in_dist   (dist_q),
        .out_valid (dv),
        .out_ctx   (dc),
        .unit_x    (ux),
        .unit_y    (uy),
        .fall      (fl)
    );

    rfk_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv),
        .in_ctx    (dc),
        .unit_x    (ux),
        .unit_y    (uy),
        .fall      (fl),
        .out_valid (pv),
        .out_res   (pres)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        skid_full_next = skid_full_reg;
        skid_next      = skid_reg;
        if (skid_full_reg) begin
            if (m_tready) begin
                out_valid_next = 1'b1;
                out_next       = skid_reg;
                skid_full_next = 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_next = pv;
            out_next       = pres;
        end else if (pv) begin
            skid_full_next = 1'b1;
            skid_next      = pres;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.force_y, out_reg.force_x};
    assign m_tuser  = {out_reg.recolor, out_reg.applied};

endmodule

// ===== src/rfk_checker.sv =====
// ----------------------------------------------------------------------------
// rfk_checker
// Port-level checks on the result stream of the radial force kernel.
// ----------------------------------------------------------------------------
module rfk_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("force without applied");

    a_recolor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("recolor without applied");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat after reset");

endmodule

bind radial_force_kernel rfk_checker u_rfk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
